// ----- rtl/rcb_pkg.sv -----
// ----------------------------------------------------------------------------
// rcb_pkg: colour balance shared types and constants
// Register codes, matrix constants, queue word and status structs.
// ----------------------------------------------------------------------------
package rcb_pkg;

  localparam int unsigned CFG_DATA_W = 14;
  localparam int unsigned CFG_IDX_W  = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONTRAST = 8'd0,
    REG_BRIGHT   = 8'd1,
    REG_HUE      = 8'd2,
    REG_SAT      = 8'd3
  } reg_idx_e;

  localparam logic [CFG_DATA_W-1:0] CONTRAST_RST = 14'd4096;
  localparam logic [CFG_DATA_W-1:0] BRIGHT_RST   = 14'd0;
  localparam logic [CFG_DATA_W-1:0] HUE_RST      = 14'd0;
  localparam logic [CFG_DATA_W-1:0] SAT_RST      = 14'd4096;

  localparam longint PI_HALF_Q30 = 64'sd1686629713;

  // constant in units of 1e-7, to Q24 with rounding
  function automatic longint q24(longint u);
    return (u * 64'sd16777216 + 64'sd5000000) / 64'sd10000000;
  endfunction

  localparam longint K_YR = q24(64'sd2568160);
  localparam longint K_YG = q24(64'sd5041540);
  localparam longint K_YB = q24(64'sd979137);
  localparam longint K_UR = q24(64'sd1482460);
  localparam longint K_UG = q24(64'sd2910200);
  localparam longint K_UB = q24(64'sd4392660);
  localparam longint K_VR = q24(64'sd4392710);
  localparam longint K_VG = q24(64'sd3678330);
  localparam longint K_VB = q24(64'sd714380);
  localparam longint O_Y  = q24(64'sd11640000);
  localparam longint O_RV = q24(64'sd15960000);
  localparam longint O_GU = q24(64'sd3910000);
  localparam longint O_GV = q24(64'sd8130000);
  localparam longint O_BU = q24(64'sd20180000);

  typedef enum logic [3:0] {
    CS_IDLE, CS_SIN, CS_COS, CS_SC, CS_SS, CS_P1, CS_P2, CS_WR, CS_OFS
  } coef_state_e;

  typedef struct packed {
    logic       bypass;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic busy;
    logic bypass;
  } coef_status_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  // round half up, then arithmetic shift right
  function automatic longint rsh(longint v, int unsigned sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  // signed matrix constant of term one or two of coefficient j
  function automatic logic signed [25:0] term_k(logic [3:0] j, logic second);
    logic signed [25:0] k;
    k = '0;
    case (j)
      4'd0: k = second ? 26'sd0 : 26'(K_YR);
      4'd1: k = second ? 26'sd0 : 26'(K_YG);
      4'd2: k = second ? 26'sd0 : 26'(K_YB);
      4'd3: k = second ? 26'(K_VR)  : -26'(K_UR);
      4'd4: k = second ? -26'(K_VG) : -26'(K_UG);
      4'd5: k = second ? -26'(K_VB) : 26'(K_UB);
      4'd6: k = second ? 26'(K_UR)  : 26'(K_VR);
      4'd7: k = second ? 26'(K_UG)  : -26'(K_VG);
      4'd8: k = second ? -26'(K_UB) : -26'(K_VB);
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/rcb_if.sv -----
// ----------------------------------------------------------------------------
// rcb_if: colour balance channel interfaces
// Pixel in, pixel out and register write channels.
// ----------------------------------------------------------------------------
interface rcb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  logic [7:0] in_alpha;
  modport source (output valid, in_red, in_green, in_blue, in_alpha, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

interface rcb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  modport source (output valid, out_red, out_green, out_blue, out_alpha, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

interface rcb_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [rcb_pkg::CFG_IDX_W-1:0]    index;
  logic [rcb_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/rcb_coef.sv -----
// ----------------------------------------------------------------------------
// rcb_coef: register file and coefficient sequencer
// Holds the settings and rebuilds the matrix one coefficient at a time.
// ----------------------------------------------------------------------------
module rcb_coef #(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int COEFF_WIDTH      = 18
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rcb_cfg_if.sink                       cfg,
  output logic signed [COEFF_WIDTH-1:0] coef_o [9],
  output logic signed [COEFF_WIDTH-1:0] luma_ofs_o,
  output rcb_pkg::coef_status_t         status_o
);

  localparam int     D   = SINE_TABLE_DEPTH;
  localparam int     IW  = $clog2(D + 1);
  localparam int     CF  = COEFF_WIDTH - 2;
  localparam longint LIM = 64'sd1 <<< (COEFF_WIDTH - 1);

  // quarter-wave sine table, built at elaboration
  logic [16:0] sine_tab [D+1];
  for (genvar k = 0; k <= D; k++) begin : g_sine
    localparam longint X  = (longint'(k) * rcb_pkg::PI_HALF_Q30 + D / 2) / D;
    localparam longint X2 = (X * X + 64'sd536870912) >>> 30;
    localparam longint T1 = ((X * X2 + 64'sd536870912) >>> 30) / 6;
    localparam longint T2 = ((T1 * X2 + 64'sd536870912) >>> 30) / 20;
    localparam longint T3 = ((T2 * X2 + 64'sd536870912) >>> 30) / 42;
    localparam longint T4 = ((T3 * X2 + 64'sd536870912) >>> 30) / 72;
    localparam longint T5 = ((T4 * X2 + 64'sd536870912) >>> 30) / 110;
    localparam longint T6 = ((T5 * X2 + 64'sd536870912) >>> 30) / 156;
    localparam longint T7 = ((T6 * X2 + 64'sd536870912) >>> 30) / 210;
    localparam longint S  = X - T1 + T2 - T3 + T4 - T5 + T6 - T7;
    localparam longint R  = (S + 64'sd8192) >>> 14;
    localparam longint E  = (S < 0) ? 64'sd0 : ((R > 64'sd65536) ? 64'sd65536 : R);
    assign sine_tab[k] = 17'(E);
  end

  function automatic logic signed [COEFF_WIDTH-1:0] mk(longint v);
    longint t;
    t = rcb_pkg::rsh(v, 52 - CF);
    if (t < -LIM) t = -LIM;
    else if (t > LIM - 1) t = LIM - 1;
    return COEFF_WIDTH'(t);
  endfunction

  rcb_pkg::coef_state_e state_q, state_d;

  logic [13:0] contrast_q, bright_q, hue_q, sat_q;
  logic [13:0] contrast_d, bright_d, hue_d, sat_d;
  logic        bypass_q;
  logic [3:0]  j_q;
  logic signed [17:0] sn_q, cs_q;
  logic signed [32:0] sc_q, ss_q;
  logic signed [63:0] p1_q, p2_q;
  logic signed [COEFF_WIDTH-1:0] coef_q [9];
  logic signed [COEFF_WIDTH-1:0] ofs_q;

  logic wr_en, reg_hit;
  assign cfg.ready = (state_q == rcb_pkg::CS_IDLE);
  assign wr_en     = cfg.valid && cfg.ready;
  assign reg_hit   = (cfg.index == rcb_pkg::REG_CONTRAST) || (cfg.index == rcb_pkg::REG_BRIGHT) ||
                     (cfg.index == rcb_pkg::REG_HUE) || (cfg.index == rcb_pkg::REG_SAT);

  always_comb begin
    contrast_d = contrast_q;
    bright_d   = bright_q;
    hue_d      = hue_q;
    sat_d      = sat_q;
    if (wr_en) begin
      case (cfg.index)
        rcb_pkg::REG_CONTRAST: contrast_d = cfg.data;
        rcb_pkg::REG_BRIGHT:   bright_d   = cfg.data;
        rcb_pkg::REG_HUE:      hue_d      = cfg.data;
        rcb_pkg::REG_SAT:      sat_d      = cfg.data;
        default: ;
      endcase
    end
  end

  // clamped settings for the arithmetic
  logic [13:0]        c, s;
  logic signed [13:0] b, h;
  logic [12:0]        ang, trig_a;
  always_comb begin
    c = (contrast_q > 14'd8192) ? 14'd8192 : contrast_q;
    s = (sat_q > 14'd8192) ? 14'd8192 : sat_q;
    b = $signed(bright_q);
    if (b > 14'sd4096) b = 14'sd4096;
    else if (b < -14'sd4096) b = -14'sd4096;
    h = $signed(hue_q);
    if (h > 14'sd4096) h = 14'sd4096;
    else if (h < -14'sd4096) h = -14'sd4096;
    ang = h[12:0];
  end

  // sine lookup with quadrant folding; cosine is a quarter turn on
  logic [23:0]        idx_w;
  logic [12:0]        idx;
  logic [16:0]        tab_v;
  logic signed [17:0] trig_v;
  always_comb begin
    trig_a = (state_q == rcb_pkg::CS_COS) ? ang + 13'd2048 : ang;
    idx_w  = (24'(trig_a[10:0]) * 24'(D) + 24'd1024) >> 11;
    idx    = (idx_w > 24'(D)) ? 13'(D) : idx_w[12:0];
    if (trig_a[11]) idx = 13'(D) - idx;
    tab_v  = sine_tab[idx[IW-1:0]];
    trig_v = trig_a[12] ? -$signed({1'b0, tab_v}) : $signed({1'b0, tab_v});
  end

  logic signed [32:0] c28, op;
  logic signed [25:0] k;
  logic signed [63:0] prod;
  always_comb begin
    c28  = $signed({3'b000, c, 16'h0000});
    op   = (state_q == rcb_pkg::CS_P2) ? ss_q : ((j_q < 4'd3) ? c28 : sc_q);
    k    = rcb_pkg::term_k(j_q, state_q == rcb_pkg::CS_P2);
    prod = 64'(k) * 64'(op);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rcb_pkg::CS_IDLE: if (wr_en && reg_hit) state_d = rcb_pkg::CS_SIN;
      rcb_pkg::CS_SIN:  state_d = rcb_pkg::CS_COS;
      rcb_pkg::CS_COS:  state_d = rcb_pkg::CS_SC;
      rcb_pkg::CS_SC:   state_d = rcb_pkg::CS_SS;
      rcb_pkg::CS_SS:   state_d = rcb_pkg::CS_P1;
      rcb_pkg::CS_P1:   state_d = rcb_pkg::CS_P2;
      rcb_pkg::CS_P2:   state_d = rcb_pkg::CS_WR;
      rcb_pkg::CS_WR:   state_d = (j_q == 4'd8) ? rcb_pkg::CS_OFS : rcb_pkg::CS_P1;
      rcb_pkg::CS_OFS:  state_d = rcb_pkg::CS_IDLE;
      default:          state_d = rcb_pkg::CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= rcb_pkg::CS_IDLE;
      contrast_q <= rcb_pkg::CONTRAST_RST;
      bright_q   <= rcb_pkg::BRIGHT_RST;
      hue_q      <= rcb_pkg::HUE_RST;
      sat_q      <= rcb_pkg::SAT_RST;
      bypass_q   <= 1'b1;
      j_q        <= '0;
    end else begin
      state_q    <= state_d;
      contrast_q <= contrast_d;
      bright_q   <= bright_d;
      hue_q      <= hue_d;
      sat_q      <= sat_d;
      if (wr_en && reg_hit) begin
        bypass_q <= (contrast_d == rcb_pkg::CONTRAST_RST) && (bright_d == rcb_pkg::BRIGHT_RST) &&
                    (hue_d == rcb_pkg::HUE_RST) && (sat_d == rcb_pkg::SAT_RST);
        j_q      <= '0;
      end else if (state_q == rcb_pkg::CS_WR) begin
        j_q <= j_q + 4'd1;
      end
    end
  end

  // matrix payload: no reset, bypass covers the power-up settings
  always_ff @(posedge clk_i) begin
    case (state_q)
      rcb_pkg::CS_SIN: sn_q <= trig_v;
      rcb_pkg::CS_COS: cs_q <= trig_v;
      rcb_pkg::CS_SC:  sc_q <= 33'($signed({1'b0, s})) * 33'(cs_q);
      rcb_pkg::CS_SS:  ss_q <= 33'($signed({1'b0, s})) * 33'(sn_q);
      rcb_pkg::CS_P1:  p1_q <= prod;
      rcb_pkg::CS_P2:  p2_q <= prod;
      rcb_pkg::CS_WR:  coef_q[j_q] <= mk(p1_q + p2_q);
      rcb_pkg::CS_OFS: begin
        automatic longint t = rcb_pkg::rsh((longint'(c) <<< 13) + (longint'(b) <<< 16)
                                           - (64'sd1 <<< 24), 28 - CF);
        if (t < -LIM) t = -LIM;
        else if (t > LIM - 1) t = LIM - 1;
        ofs_q <= COEFF_WIDTH'(t);
      end
      default: ;
    endcase
  end

  assign coef_o          = coef_q;
  assign luma_ofs_o      = ofs_q;
  assign status_o.busy   = (state_q != rcb_pkg::CS_IDLE);
  assign status_o.bypass = bypass_q;

endmodule

// ----- rtl/rcb_front.sv -----
// ----------------------------------------------------------------------------
// rcb_front: pixel intake and decoupling queue
// Accepts words, tags them with the bypass mode, holds two in a queue.
// ----------------------------------------------------------------------------
module rcb_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  rcb_in_if.sink                 pix,
  input  rcb_pkg::coef_status_t  coef_st_i,
  output rcb_pkg::pixel_t        word_o,
  output logic                   word_valid_o,
  input  logic                   pop_i,
  output rcb_pkg::queue_status_t status_o
);

  rcb_pkg::pixel_t mem_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;
  logic            push, pop;

  assign status_o.full  = (cnt_q == 2'd2);
  assign status_o.empty = (cnt_q == 2'd0);
  // hold intake while the matrix is being rebuilt
  assign pix.ready      = !status_o.full && !coef_st_i.busy;
  assign push           = pix.valid && pix.ready;
  assign pop            = pop_i && !status_o.empty;
  assign word_valid_o   = !status_o.empty;
  assign word_o         = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= '{bypass: coef_st_i.bypass, red: pix.in_red, green: pix.in_green,
                       blue: pix.in_blue, alpha: pix.in_alpha};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= !wr_q;
      if (pop)  rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- rtl/rcb_back.sv -----
// ----------------------------------------------------------------------------
// rcb_back: colour balance datapath
// Matrix, clamp, YUV to RGB and rounding over four stalling stages.
// ----------------------------------------------------------------------------
module rcb_back #(
  parameter int COEFF_WIDTH = 18
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rcb_pkg::pixel_t               word_i,
  input  logic                          word_valid_i,
  output logic                          pop_o,
  input  logic signed [COEFF_WIDTH-1:0] coef_i [9],
  input  logic signed [COEFF_WIDTH-1:0] luma_ofs_i,
  rcb_out_if.source                     out
);

  localparam int CW  = COEFF_WIDTH;
  localparam int CF  = CW - 2;
  localparam int PW1 = CW + 9;
  localparam int AW  = CW + 11;
  localparam int CHW = CF + 8;
  localparam int DW  = CF + 9;
  localparam int PW3 = CF + 36;
  localparam int SW  = CF + 38;

  function automatic logic [7:0] to8(logic signed [SW-1:0] x);
    logic signed [SW-1:0] top, t;
    top = SW'(255) <<< (24 + CF);
    t   = (x + (SW'(1) <<< (23 + CF))) >>> (24 + CF);
    if (x <= 0) return 8'd0;
    if (x >= top) return 8'd255;
    return t[7:0];
  endfunction

  logic en;
  assign en    = !out.valid || out.ready;
  assign pop_o = en && word_valid_i;

  // stage 1: nine coefficient products
  logic                  v1_q;
  rcb_pkg::pixel_t       w1_q;
  logic signed [PW1-1:0] m1_q [9];
  logic signed [PW1-1:0] px [3];
  assign px[0] = PW1'($signed({1'b0, word_i.red}));
  assign px[1] = PW1'($signed({1'b0, word_i.green}));
  assign px[2] = PW1'($signed({1'b0, word_i.blue}));

  // stage 2: row sums with offsets, clamp to the unit range
  logic                  v2_q;
  rcb_pkg::pixel_t       w2_q;
  logic [CHW-1:0]        ch_q [3];
  logic signed [AW-1:0]  acc [3];
  logic signed [AW-1:0]  full, half, ofs;
  always_comb begin
    full = AW'(255) <<< CF;
    half = AW'(255) <<< (CF - 1);
    ofs  = (AW'(luma_ofs_i) <<< 8) - AW'(luma_ofs_i);
    for (int i = 0; i < 3; i++) begin
      acc[i] = AW'(m1_q[3*i]) + AW'(m1_q[3*i+1]) + AW'(m1_q[3*i+2]) + ((i == 0) ? ofs : half);
    end
  end

  // stage 3: YUV back to RGB products
  logic                  v3_q;
  rcb_pkg::pixel_t       w3_q;
  logic signed [DW-1:0]  yd, ud, vd;
  logic signed [PW3-1:0] py_q, prv_q, pgu_q, pgv_q, pbu_q;
  assign yd = $signed({1'b0, ch_q[0]}) - (DW'(255) <<< (CF - 4));
  assign ud = $signed({1'b0, ch_q[1]}) - (DW'(255) <<< (CF - 1));
  assign vd = $signed({1'b0, ch_q[2]}) - (DW'(255) <<< (CF - 1));

  // stage 4: sums, rounding and the output register
  logic signed [SW-1:0] r_s, g_s, b_s;
  assign r_s = SW'(py_q) + SW'(prv_q);
  assign g_s = SW'(py_q) - SW'(pgu_q) - SW'(pgv_q);
  assign b_s = SW'(py_q) + SW'(pbu_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      out.valid <= 1'b0;
    end else if (en) begin
      v1_q      <= pop_o;
      v2_q      <= v1_q;
      v3_q      <= v2_q;
      out.valid <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w1_q <= word_i;
      for (int i = 0; i < 9; i++) m1_q[i] <= PW1'(coef_i[i]) * px[i % 3];
      w2_q <= w1_q;
      for (int i = 0; i < 3; i++) begin
        if (acc[i] < 0) ch_q[i] <= '0;
        else if (acc[i] > full) ch_q[i] <= CHW'(full);
        else ch_q[i] <= CHW'(acc[i]);
      end
      w3_q  <= w2_q;
      py_q  <= PW3'(rcb_pkg::O_Y)  * PW3'(yd);
      prv_q <= PW3'(rcb_pkg::O_RV) * PW3'(vd);
      pgu_q <= PW3'(rcb_pkg::O_GU) * PW3'(ud);
      pgv_q <= PW3'(rcb_pkg::O_GV) * PW3'(vd);
      pbu_q <= PW3'(rcb_pkg::O_BU) * PW3'(ud);
      out.out_red   <= w3_q.bypass ? w3_q.red   : to8(r_s);
      out.out_green <= w3_q.bypass ? w3_q.green : to8(g_s);
      out.out_blue  <= w3_q.bypass ? w3_q.blue  : to8(b_s);
      out.out_alpha <= w3_q.alpha;
    end
  end

endmodule

// ----- rtl/rgba_color_balance_core.sv -----
// ----------------------------------------------------------------------------
// rgba_color_balance_core: RGBA colour balance, top level
// Brightness, contrast, hue and saturation on a BT.601 YUV round trip.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                   | handshake
//  pix_i    | in  | in_red, in_green, in_blue, in_alpha (8b)  | valid/ready
//  pix_o    | out | out_red, out_green, out_blue, out_alpha   | valid/ready
//  cfg_i    | in  | index (8b), data (14b)                    | valid/ready
//
// One word a cycle while the output is not stalled and no rebuild is running;
// a word passes the two-word queue, then the product, clamp and conversion
// stages, then the output register. A register write rebuilds the matrix on one
// shared multiplier; intake and further writes are held until it is done.
// Reset puts the settings at their defaults with bypass on: words pass as is.
// An output stall freezes the datapath; the queue keeps taking up to two words.
// ----------------------------------------------------------------------------
module rgba_color_balance_core #(
  parameter int SINE_TABLE_DEPTH = 256,
  parameter int COEFF_WIDTH      = 18
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rcb_in_if.sink     pix_i,
  rcb_out_if.source  pix_o,
  rcb_cfg_if.sink    cfg_i
);

  rcb_pkg::coef_status_t  coef_st;
  rcb_pkg::queue_status_t q_st;
  rcb_pkg::pixel_t        word;
  logic                   word_valid, pop;
  logic signed [COEFF_WIDTH-1:0] coef [9];
  logic signed [COEFF_WIDTH-1:0] luma_ofs;

  // settings and derived matrix
  rcb_coef #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH),
    .COEFF_WIDTH     (COEFF_WIDTH)
  ) u_coef (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg       (cfg_i),
    .coef_o    (coef),
    .luma_ofs_o(luma_ofs),
    .status_o  (coef_st)
  );

  // intake, bypass tag and queue
  rcb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix         (pix_i),
    .coef_st_i   (coef_st),
    .word_o      (word),
    .word_valid_o(word_valid),
    .pop_i       (pop),
    .status_o    (q_st)
  );

  // arithmetic stages and output register
  rcb_back #(
    .COEFF_WIDTH(COEFF_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .word_i      (word),
    .word_valid_i(word_valid),
    .pop_o       (pop),
    .coef_i      (coef),
    .luma_ofs_i  (luma_ofs),
    .out         (pix_o)
  );

  // no word may enter while the matrix is half rebuilt
  a_no_intake_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_i.ready |-> !coef_st.busy)
    else $error("intake open during matrix rebuild");

  // a write to a real register starts the rebuild
  a_write_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_i.valid && cfg_i.ready && (cfg_i.index == rcb_pkg::REG_CONTRAST ||
     cfg_i.index == rcb_pkg::REG_BRIGHT || cfg_i.index == rcb_pkg::REG_HUE ||
     cfg_i.index == rcb_pkg::REG_SAT)) |=> coef_st.busy)
    else $error("register write did not start rebuild");

  // a full queue must close intake
  a_queue_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_st.full |-> !pix_i.ready)
    else $error("intake open with queue full");

endmodule
